### hdl/icf_pkg.sv
// shared types, codes and helpers for the integer conversion formatter
// used by icf_front, icf_queue, icf_back and the top level
package icf_pkg;

  localparam int VALUE_W     = 64;
  localparam int WIDTH_W     = 7;
  localparam int PREC_W      = 6;
  localparam int DIGIT_W     = 4;
  localparam int NUM_DIGITS  = 22;
  localparam int BCD_DIGITS  = 20;
  localparam int ND_W        = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam int MAX_WIDTH_DEFAULT     = 64;
  localparam int MAX_PRECISION_DEFAULT = 60;
  localparam logic [WIDTH_W-1:0] PTR_DIGITS = 7'd16;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_OCT  = 3'd2;
  localparam logic [2:0] MODE_LHEX = 3'd3;
  localparam logic [2:0] MODE_UHEX = 3'd4;
  localparam logic [2:0] MODE_PTR  = 3'd5;

  localparam logic [2:0] LEN_CHAR  = 3'd0;
  localparam logic [2:0] LEN_SHORT = 3'd1;
  localparam logic [2:0] LEN_INT   = 3'd2;
  localparam logic [2:0] LEN_LONG  = 3'd3;
  localparam logic [2:0] LEN_LLONG = 3'd4;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOWX  = 8'h78;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;

  typedef struct packed {
    logic [VALUE_W-1:0] mag;
    logic [1:0]         base;
    logic               lower;
    logic               has_sign;
    logic [7:0]         sign_char;
    logic [1:0]         prefix;
    logic               zero;
    logic               left;
    logic [WIDTH_W-1:0] width;
    logic [PREC_W-1:0]  prec;
  } icf_item_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic lower);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else if (lower) begin
      c = CH_LOWA + {4'b0, d - 4'd10};
    end else begin
      c = CH_UPA + {4'b0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

### hdl/icf_front.sv
// front part: classifies one conversion request into a queue word
// depends on icf_pkg
module icf_front #(
  parameter int MAX_WIDTH     = icf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_PRECISION = icf_pkg::MAX_PRECISION_DEFAULT
) (
  input  logic [63:0]      value,
  input  logic [2:0]       mode,
  input  logic [2:0]       length,
  input  logic             alt_form,
  input  logic             zero_pad,
  input  logic             left_justify,
  input  logic             space_sign,
  input  logic             plus_sign,
  input  logic [6:0]       field_width,
  input  logic             width_given,
  input  logic [5:0]       precision,
  output logic             known,
  output icf_pkg::icf_item_t item
);

  logic [63:0] mask;
  logic [63:0] masked;
  logic        sbit;
  logic        neg;
  logic        hex;

  always_comb begin
    mask = '1;
    sbit = value[63];
    if (mode != icf_pkg::MODE_PTR) begin
      case (length)
        icf_pkg::LEN_CHAR: begin
          mask = 64'h0000_0000_0000_00FF;
          sbit = value[7];
        end
        icf_pkg::LEN_SHORT: begin
          mask = 64'h0000_0000_0000_FFFF;
          sbit = value[15];
        end
        icf_pkg::LEN_LONG, icf_pkg::LEN_LLONG: begin
          mask = '1;
          sbit = value[63];
        end
        default: begin
          mask = 64'h0000_0000_FFFF_FFFF;
          sbit = value[31];
        end
      endcase
    end
    masked = value & mask;
    neg    = (mode == icf_pkg::MODE_SDEC) && sbit;
    hex    = (mode == icf_pkg::MODE_LHEX) || (mode == icf_pkg::MODE_UHEX) ||
             (mode == icf_pkg::MODE_PTR);
    known  = (mode <= icf_pkg::MODE_PTR);

    item.mag = neg ? ((~masked + 64'd1) & mask) : masked;
    if (hex) begin
      item.base = icf_pkg::BASE_HEX;
    end else if (mode == icf_pkg::MODE_OCT) begin
      item.base = icf_pkg::BASE_OCT;
    end else begin
      item.base = icf_pkg::BASE_DEC;
    end
    item.lower     = (mode == icf_pkg::MODE_LHEX);
    item.has_sign  = (mode == icf_pkg::MODE_SDEC) && (neg || plus_sign || space_sign);
    item.sign_char = neg ? icf_pkg::CH_MINUS : (plus_sign ? icf_pkg::CH_PLUS : icf_pkg::CH_SPACE);
    item.prefix    = alt_form ? (hex ? 2'd2 : 2'd1) : 2'd0;
    item.width     = (field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : field_width;
    item.prec      = (precision > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION) : precision;
    item.zero      = zero_pad;
    if ((mode == icf_pkg::MODE_PTR) && !width_given) begin
      item.width = icf_pkg::PTR_DIGITS;
      item.zero  = 1'b1;
    end
    if (left_justify) begin
      item.zero = 1'b0;
    end
    item.left = left_justify;
  end

endmodule

### hdl/icf_queue.sv
// short queue of classified words between front and back
// depends on icf_pkg
module icf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  icf_pkg::icf_item_t push_item,
  input  logic               pop,
  output icf_pkg::icf_item_t head,
  output logic               empty,
  output logic               full
);

  localparam int PTR_W = (icf_pkg::QUEUE_DEPTH > 1) ? $clog2(icf_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(icf_pkg::QUEUE_DEPTH + 1);

  icf_pkg::icf_item_t entries [icf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(icf_pkg::QUEUE_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(icf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(icf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hdl/icf_back.sv
// back part: digit extraction, digit count and character sequencing
// depends on icf_pkg
module icf_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  icf_pkg::icf_item_t q_head,
  output logic               q_pop,
  output logic               valid,
  output logic [7:0]         out_char,
  output logic               last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_SETUP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  localparam int DIG_BITS = icf_pkg::NUM_DIGITS * icf_pkg::DIGIT_W;
  localparam int BCD_BITS = icf_pkg::BCD_DIGITS * icf_pkg::DIGIT_W;

  logic [2:0]                 state;
  icf_pkg::icf_item_t         item;
  logic [63:0]                shreg;
  logic [BCD_BITS-1:0]        bcd;
  logic [BCD_BITS-1:0]        bcd_adj;
  logic [DIG_BITS-1:0]        digits;
  logic [DIG_BITS-1:0]        load_digits;
  logic [65:0]                mag_ext;
  logic [5:0]                 iter;
  logic [icf_pkg::ND_W-1:0]   nd;
  logic [icf_pkg::ND_W-1:0]   nd_cnt;
  logic [6:0]                 lsp_cnt;
  logic [6:0]                 zp_cnt;
  logic [5:0]                 pz_cnt;
  logic [6:0]                 tsp_cnt;
  logic                       sign_pend;
  logic                       pre0_pend;
  logic                       prex_pend;
  logic [6:0]                 remain;
  logic [5:0]                 body;
  logic [6:0]                 used;
  logic [6:0]                 pad;
  logic [7:0]                 emit_char;

  assign q_pop = (state == ST_IDLE) && !q_empty;

  // add-3 correction for shift-and-add binary to bcd
  always_comb begin
    for (int i = 0; i < icf_pkg::BCD_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    mag_ext = {2'b00, q_head.mag};
    load_digits = '0;
    if (q_head.base == icf_pkg::BASE_OCT) begin
      for (int i = 0; i < icf_pkg::NUM_DIGITS; i++) begin
        load_digits[i*4 +: 4] = {1'b0, mag_ext[i*3 +: 3]};
      end
    end else begin
      load_digits = {{(DIG_BITS-64){1'b0}}, q_head.mag};
    end
  end

  always_comb begin
    body = (6'(nd) > item.prec) ? 6'(nd) : item.prec;
    used = 7'(body) + 7'(item.prefix) + 7'(item.has_sign);
    pad  = (item.width > used) ? item.width - used : 7'd0;
  end

  always_comb begin
    if (lsp_cnt != '0) begin
      emit_char = icf_pkg::CH_SPACE;
    end else if (sign_pend) begin
      emit_char = item.sign_char;
    end else if (pre0_pend) begin
      emit_char = icf_pkg::CH_ZERO;
    end else if (prex_pend) begin
      emit_char = item.lower ? icf_pkg::CH_LOWX : icf_pkg::CH_UPX;
    end else if ((zp_cnt != '0) || (pz_cnt != '0)) begin
      emit_char = icf_pkg::CH_ZERO;
    end else if (nd_cnt != '0) begin
      emit_char = icf_pkg::digit_char(digits[DIG_BITS-1 -: 4], item.lower);
    end else begin
      emit_char = icf_pkg::CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            item   <= q_head;
            shreg  <= q_head.mag;
            bcd    <= '0;
            iter   <= '0;
            nd     <= icf_pkg::ND_W'(icf_pkg::NUM_DIGITS);
            digits <= load_digits;
            state  <= (q_head.base == icf_pkg::BASE_DEC) ? ST_CONV : ST_NORM;
          end
        end
        ST_CONV: begin
          bcd   <= {bcd_adj[BCD_BITS-2:0], shreg[63]};
          shreg <= {shreg[62:0], 1'b0};
          iter  <= iter + 1'b1;
          if (iter == 6'd63) begin
            digits <= {{(DIG_BITS-BCD_BITS){1'b0}}, bcd_adj[BCD_BITS-2:0], shreg[63]};
            state  <= ST_NORM;
          end
        end
        ST_NORM: begin
          // drop leading zero digits, keep at least one
          if ((nd != icf_pkg::ND_W'(1)) && (digits[DIG_BITS-1 -: 4] == 4'd0)) begin
            digits <= {digits[DIG_BITS-5:0], 4'd0};
            nd     <= nd - 1'b1;
          end else begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          lsp_cnt   <= (!item.zero && !item.left) ? pad : 7'd0;
          zp_cnt    <= item.zero ? pad : 7'd0;
          tsp_cnt   <= item.left ? pad : 7'd0;
          pz_cnt    <= (item.prec > 6'(nd)) ? item.prec - 6'(nd) : 6'd0;
          nd_cnt    <= nd;
          sign_pend <= item.has_sign;
          pre0_pend <= (item.prefix != 2'd0);
          prex_pend <= (item.prefix == 2'd2);
          remain    <= used + pad;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          valid    <= 1'b1;
          out_char <= emit_char;
          last     <= (remain == 7'd1);
          remain   <= remain - 1'b1;
          if (lsp_cnt != '0) begin
            lsp_cnt <= lsp_cnt - 1'b1;
          end else if (sign_pend) begin
            sign_pend <= 1'b0;
          end else if (pre0_pend) begin
            pre0_pend <= 1'b0;
          end else if (prex_pend) begin
            prex_pend <= 1'b0;
          end else if (zp_cnt != '0) begin
            zp_cnt <= zp_cnt - 1'b1;
          end else if (pz_cnt != '0) begin
            pz_cnt <= pz_cnt - 1'b1;
          end else if (nd_cnt != '0) begin
            nd_cnt <= nd_cnt - 1'b1;
            digits <= {digits[DIG_BITS-5:0], 4'd0};
          end else if (tsp_cnt != '0) begin
            tsp_cnt <= tsp_cnt - 1'b1;
          end
          if (remain == 7'd1) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_last_has_valid: assert property (@(posedge clk) disable iff (rst)
    last && valid |=> !valid)
    else $error("word strobed right after a final character");

  a_word_train: assert property (@(posedge clk) disable iff (rst)
    valid && !last |=> valid)
    else $error("gap inside a character train");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_NORM |-> nd != '0)
    else $error("digit count fell to zero");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !valid && (state != ST_IDLE))
    else $error("pop did not start a conversion");

  a_emit_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && remain == 7'd1 |-> lsp_cnt == '0 && zp_cnt == '0 && pz_cnt == '0)
    else $error("final character with padding still pending");

endmodule

### hdl/integer_conversion_formatter.sv
// top level of the integer conversion formatter: front, queue and back
// depends on icf_pkg, icf_front, icf_queue, icf_back
//
// A conversion is taken when start is high and busy is low; busy rises only when the
// two-word queue is full. Characters leave one per cycle on out_char with valid high,
// last marks the final one, and the receiver cannot stall them. A decimal item is
// loaded, passes through the shift-and-add binary to bcd loop, trims leading zero digits
// (keeping at least one), goes through a setup state and then gives its characters
// (up to 64); octal and hex skip the bcd loop. An unknown mode is taken and gives nothing.
module integer_conversion_formatter #(
  parameter int MAX_WIDTH     = icf_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_PRECISION = icf_pkg::MAX_PRECISION_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value,
  input  logic [2:0]  mode,
  input  logic [2:0]  length,
  input  logic        alt_form,
  input  logic        zero_pad,
  input  logic        left_justify,
  input  logic        space_sign,
  input  logic        plus_sign,
  input  logic [6:0]  field_width,
  input  logic        width_given,
  input  logic [5:0]  precision,
  output logic        valid,
  output logic [7:0]  out_char,
  output logic        last
);

  icf_pkg::icf_item_t front_item;
  icf_pkg::icf_item_t q_head;
  logic               known;
  logic               q_empty;
  logic               q_full;
  logic               q_pop;
  logic               push;

  assign busy = q_full;
  assign push = start && !q_full && known;

  icf_front #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_PRECISION (MAX_PRECISION)
  ) u_front (
    .value        (value),
    .mode         (mode),
    .length       (length),
    .alt_form     (alt_form),
    .zero_pad     (zero_pad),
    .left_justify (left_justify),
    .space_sign   (space_sign),
    .plus_sign    (plus_sign),
    .field_width  (field_width),
    .width_given  (width_given),
    .precision    (precision),
    .known        (known),
    .item         (front_item)
  );

  icf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  icf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .valid    (valid),
    .out_char (out_char),
    .last     (last)
  );

endmodule
